[rtl/rsct_pkg.sv]
// shared types and constants of the resizing stack capacity tracker
// no dependencies; imported by the interfaces and every module

package rsct_pkg;

  // default sizing, handed to the top level parameters
  localparam int DEFAULT_DEPTH      = 1024;
  localparam int DEFAULT_DATA_WIDTH = 32;

  // fixed field widths of the channels and the configuration port
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 11;
  localparam int RSZ_W     = 16;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_FLOOR     = 1'b1;

  // reset capacity and the word answered for a pop on an empty stack
  localparam int                 CAP_RESET      = 10;
  localparam logic [WORD_W-1:0]  EMPTY_POP_WORD = 32'hFFFF_FF9D;

  // result of one request, before the popped word is known
  typedef struct packed {
    logic             ok;
    logic             from_mem;
    logic             empty_pop;
    logic [CNT_W-1:0] fill_count;
    logic [CNT_W-1:0] capacity_now;
    logic [CNT_W-1:0] peak_capacity;
    logic [RSZ_W-1:0] resizes;
  } result_t;

endpackage

[rtl/rsct_ifs.sv]
// valid/ready channel interfaces of the resizing stack capacity tracker
// depends on rsct_pkg

interface rsct_in_if import rsct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface rsct_out_if import rsct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [WORD_W-1:0] popped_value;
  logic        [CNT_W-1:0]  fill_count;
  logic        [CNT_W-1:0]  capacity_now;
  logic        [CNT_W-1:0]  peak_capacity;
  logic        [RSZ_W-1:0]  resizes;

  modport source (output valid, output ok, output popped_value, output fill_count,
                  output capacity_now, output peak_capacity, output resizes,
                  input ready);
  modport sink   (input valid, input ok, input popped_value, input fill_count,
                  input capacity_now, input peak_capacity, input resizes,
                  output ready);
endinterface

[rtl/rsct_store.sv]
// stack word memory: one write port, one read port with registered data
// depends on rsct_pkg for defaults

module rsct_store import rsct_pkg::*; #(
  parameter int DEPTH      = DEFAULT_DEPTH,
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rsct_core.sv]
// fill, capacity, peak and resize count registers with their update logic
// depends on rsct_pkg; drives the write and read ports of rsct_store

module rsct_core import rsct_pkg::*; #(
  parameter int DEPTH      = DEFAULT_DEPTH,
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_fire,
  input  logic                  in_kind,
  input  logic [WORD_W-1:0]     in_push_value,
  output result_t               res_nxt,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr
);

  localparam int CW       = $clog2(DEPTH + 1);
  localparam int GW       = CW + 3;
  localparam int CAP_INIT = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [CW-1:0]    fill_r, fill_nxt;
  logic [CW-1:0]    cap_r, cap_nxt;
  logic [CW-1:0]    peak_r, peak_nxt;
  logic [RSZ_W-1:0] rsz_r, rsz_nxt;
  logic [CFG_W-1:0] floor_r;

  logic [GW-1:0] cap_x7;
  logic [GW-1:0] grown_q;
  logic [CW-1:0] grown;
  logic [CW-1:0] cap_push;
  logic [CW-1:0] fill_dec;
  logic [CW-1:0] half_lim;
  logic          is_pop;
  logic          grow_en;
  logic          push_ok;
  logic          pop_ok;
  logic          shrink_en;

  function automatic logic [CW-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > 32'(DEPTH)) begin
      r = CW'(DEPTH);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  always_comb begin
    is_pop = (in_kind == KIND_POP);

    // grow to floor(cap*7/4), capped at the physical depth
    cap_x7  = (GW'(cap_r) << 3) - GW'(cap_r);
    grown_q = cap_x7 >> 2;
    if (grown_q > GW'(DEPTH)) begin
      grown = CW'(DEPTH);
    end else begin
      grown = grown_q[CW-1:0];
    end
    grow_en  = !is_pop && (fill_r >= cap_r) && (grown > cap_r);
    cap_push = grow_en ? grown : cap_r;
    push_ok  = !is_pop && (fill_r < cap_push);

    // pop and halving rule
    pop_ok    = is_pop && (fill_r != '0);
    fill_dec  = fill_r - CW'(1);
    half_lim  = (cap_r - CW'(1)) >> 1;
    shrink_en = pop_ok && (fill_dec <= half_lim) && (32'(cap_r) > 32'(floor_r))
                && (cap_r >= CW'(2));

    fill_nxt = fill_r;
    if (push_ok) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop_ok) begin
      fill_nxt = fill_dec;
    end

    cap_nxt = cap_push;
    if (shrink_en) begin
      cap_nxt = cap_r >> 1;
    end

    peak_nxt = (grow_en && (grown > peak_r)) ? grown : peak_r;

    rsz_nxt = rsz_r;
    if ((grow_en || shrink_en) && (rsz_r != '1)) begin
      rsz_nxt = rsz_r + RSZ_W'(1);
    end
  end

  always_comb begin
    res_nxt.ok            = push_ok || pop_ok;
    res_nxt.from_mem      = pop_ok;
    res_nxt.empty_pop     = is_pop && !pop_ok;
    res_nxt.fill_count    = CNT_W'(fill_nxt);
    res_nxt.capacity_now  = CNT_W'(cap_nxt);
    res_nxt.peak_capacity = CNT_W'(peak_nxt);
    res_nxt.resizes       = rsz_nxt;
  end

  // words enter zero-extended from the 32-bit field, then cut to the store width
  assign mem_we    = in_fire && push_ok;
  assign mem_waddr = fill_r[AW-1:0];
  assign mem_wdata = DATA_WIDTH'(64'(in_push_value));
  assign mem_re    = in_fire && pop_ok;
  assign mem_raddr = fill_dec[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      cap_r   <= CW'(CAP_INIT);
      peak_r  <= CW'(CAP_INIT);
      rsz_r   <= '0;
      floor_r <= CFG_W'(CAP_RESET);
    end else if (cfg_we) begin
      if (cfg_idx == CFG_INITIAL_CAPACITY) begin
        fill_r <= '0;
        cap_r  <= clamp_cap(cfg_wdata);
        peak_r <= clamp_cap(cfg_wdata);
        rsz_r  <= '0;
      end else if (cfg_idx == CFG_SHRINK_FLOOR) begin
        floor_r <= cfg_wdata;
      end
    end else if (in_fire) begin
      fill_r <= fill_nxt;
      cap_r  <= cap_nxt;
      peak_r <= peak_nxt;
      rsz_r  <= rsz_nxt;
    end
  end

endmodule

[rtl/resizing_stack_capacity_tracker_top.sv]
// top level of the resizing stack capacity tracker
// depends on rsct_pkg, rsct_ifs, rsct_store and rsct_core

// LIFO stack of DEPTH words whose logical capacity grows by 7/4 on a push
// into a full stack (capped at DEPTH) and halves after a pop that leaves it
// less than half used, as long as the capacity exceeds shrink_floor. Every
// request (push or pop) gives exactly one result, registered in the cycle
// after acceptance; a new request is taken every cycle as long as the
// result register is empty or being drained. The rate is set by the stack
// memory, which takes one write (push) or one registered read (pop) per
// cycle. The memory has no reset and needs no clearing pass: a pop only
// reads words an earlier push wrote. Writing initial_capacity empties the
// stack and restarts capacity, peak and the resize count; configuration
// writes are meant for an idle block.

module resizing_stack_capacity_tracker_top import rsct_pkg::*; #(
  parameter int DEPTH      = DEFAULT_DEPTH,
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  rsct_in_if.sink              in_chan,
  rsct_out_if.source           out_chan
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  in_fire;
  result_t               res_nxt;
  result_t               res_r;
  logic                  out_valid_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [63:0]           rdata_wide;

  // result register frees itself in the same cycle it is drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  rsct_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_fire       (in_fire),
    .in_kind       (in_chan.kind),
    .in_push_value (in_chan.push_value),
    .res_nxt       (res_nxt),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr)
  );

  // read data is captured at the same edge as the result register
  rsct_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  // popped word: memory data for a good pop, marker word for an empty pop,
  // zero for any push
  assign rdata_wide = 64'(mem_rdata);

  always_comb begin
    if (res_r.from_mem) begin
      out_chan.popped_value = rdata_wide[WORD_W-1:0];
    end else if (res_r.empty_pop) begin
      out_chan.popped_value = EMPTY_POP_WORD;
    end else begin
      out_chan.popped_value = '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ok            = res_r.ok;
  assign out_chan.fill_count    = res_r.fill_count;
  assign out_chan.capacity_now  = res_r.capacity_now;
  assign out_chan.peak_capacity = res_r.peak_capacity;
  assign out_chan.resizes       = res_r.resizes;

endmodule
